>>> rtl/core/aat_pkg.sv
`timescale 1ns / 1ps

package aat_pkg;

    // field and register widths
    localparam int SLOT_W      = 16;
    localparam int RATE_W      = 32;
    localparam int TOTAL_W     = 17;
    localparam int MCNT_W      = 11;
    localparam int MIDX_OUT_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SLOT_W-1:0]  LIMIT_RESET   = 16'd3;
    localparam logic [MCNT_W-1:0]  METER_CNT_MAX = 11'h7FF;
    localparam logic [TOTAL_W-1:0] SCAN_CNT_MAX  = 17'h1FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RATE    = 2'd2;

    // input commands
    localparam logic CMD_OBSERVE  = 1'b0;
    localparam logic CMD_END_SCAN = 1'b1;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_RATE    = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_DIV,
        SEQ_READ,
        SEQ_EMIT,
        SEQ_CLEAR
    } seq_state_t;

endpackage

>>> rtl/core/aat_divider.sv
`timescale 1ns / 1ps

// Two-lane restoring divider sharing one divisor; gives ceil(a/d) and ceil(b/d).
module aat_divider
    import aat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] divisor,
    input  logic [RATE_W-1:0]  dividend_a,
    input  logic [RATE_W-1:0]  dividend_b,
    output logic               done,
    output logic [RATE_W-1:0]  ceil_a,
    output logic [RATE_W-1:0]  ceil_b
);

    localparam int STEP_W = $clog2(RATE_W);

    logic                busy_reg;
    logic                fix_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TOTAL_W-1:0]  dvs_reg;
    logic [TOTAL_W-1:0]  rem_a_reg;
    logic [TOTAL_W-1:0]  rem_b_reg;
    logic [RATE_W-1:0]   q_a_reg;
    logic [RATE_W-1:0]   q_b_reg;
    logic [RATE_W-1:0]   res_a_reg;
    logic [RATE_W-1:0]   res_b_reg;

    logic [TOTAL_W-1:0]  rem_a_next;
    logic [TOTAL_W-1:0]  rem_b_next;
    logic [RATE_W-1:0]   q_a_next;
    logic [RATE_W-1:0]   q_b_next;

    function automatic logic [TOTAL_W+RATE_W-1:0] div_step(
        input logic [TOTAL_W-1:0] rem,
        input logic [RATE_W-1:0]  q,
        input logic [TOTAL_W-1:0] dvs
    );
        logic [TOTAL_W:0] trial;
        logic [TOTAL_W:0] diff;
        trial = {rem, q[RATE_W-1]};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs})
        begin
            div_step = {diff[TOTAL_W-1:0], q[RATE_W-2:0], 1'b1};
        end
        else
        begin
            div_step = {trial[TOTAL_W-1:0], q[RATE_W-2:0], 1'b0};
        end
    endfunction

    always_comb
    begin
        {rem_a_next, q_a_next} = div_step(rem_a_reg, q_a_reg, dvs_reg);
        {rem_b_next, q_b_next} = div_step(rem_b_reg, q_b_reg, dvs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(RATE_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg   <= divisor;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            q_a_reg   <= dividend_a;
            q_b_reg   <= dividend_b;
        end
        else if (busy_reg)
        begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            q_a_reg   <= q_a_next;
            q_b_reg   <= q_b_next;
        end
        if (fix_reg)
        begin
            // round up on a nonzero remainder; cannot overflow as q < 2^32 - 1 then
            res_a_reg <= q_a_reg + RATE_W'(rem_a_reg != '0);
            res_b_reg <= q_b_reg + RATE_W'(rem_b_reg != '0);
        end
    end

    assign done   = done_reg;
    assign ceil_a = res_a_reg;
    assign ceil_b = res_b_reg;

endmodule

>>> rtl/core/address_activity_aging_table_top.sv
`timescale 1ns / 1ps

// Idle-timeout aging table. Observe items run one per cycle while the output
// is not stalled: the idle counter store is a single-port-write, registered-read
// memory, read when the item is taken and written back when the item leaves the
// observe stage, with the last write forwarded so back-to-back items on the same
// slot are exact; each verdict passes through the observe stage register and the
// output register. An end-of-scan item first enters a start state; unless nothing
// went inactive, it then runs the two-lane restoring divider and walks the meter
// count memory, reading each nonzero meter and emitting its rate (waiting on any
// output stall), stopping after the last nonzero meter, or after all of them
// when none has a count; then a clear state clears the scan counts; no item is
// taken meanwhile. After reset a clearing pass loads every one of the
// min(ADDRESS_SLOTS, 65536) counters with 3, one entry a cycle, during which no item is
// taken; configuration writes are taken at any time.
module address_activity_aging_table_top
    import aat_pkg::*;
#(
    parameter int ADDRESS_SLOTS   = 65536,
    parameter int SLOTS_PER_METER = 1024,
    parameter int METER_GROUPS    = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [SLOT_W-1:0]     address_index,
    input  logic                  seen,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [SLOT_W-1:0]     slot,
    output logic                  set_global_active,
    output logic                  set_global_inactive,
    output logic                  clear_flag,
    output logic [MIDX_OUT_W-1:0] meter_index,
    output logic [RATE_W-1:0]     meter_average_rate,
    output logic [RATE_W-1:0]     meter_peak_rate,
    output logic                  last
);

    localparam int MEM_DEPTH = (ADDRESS_SLOTS < 65536) ? ADDRESS_SLOTS : 65536;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int MIDX_W    = (METER_GROUPS > 1) ? $clog2(METER_GROUPS) : 1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(MEM_DEPTH);
    localparam int PROD_W    = RATE_W + MCNT_W;

    // configuration
    logic [SLOT_W-1:0] idle_limit_reg;
    logic [RATE_W-1:0] average_rate_budget_reg;
    logic [RATE_W-1:0] peak_rate_budget_reg;

    // clearing pass
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    // handshake
    logic out_free;
    logic s1_adv;
    logic in_acc;
    logic obs_acc;
    logic eos_acc;

    // observe stage
    logic              s1_valid_reg;
    logic [SLOT_W-1:0] s1_addr_reg;
    logic              s1_seen_reg;
    logic              s1_in_range_reg;
    logic [MIDX_W-1:0] s1_m_reg;
    logic              s1_m_ok_reg;
    logic              s1_mvalid_reg;

    // idle counter store
    logic [SLOT_W-1:0] cnt_mem [MEM_DEPTH];
    logic [SLOT_W-1:0] cnt_rdata_reg;
    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [SLOT_W-1:0] cnt_wdata;
    logic              lw_valid_reg;
    logic [IDX_W-1:0]  lw_idx_reg;
    logic [SLOT_W-1:0] lw_data_reg;

    // meter count store
    logic [MCNT_W-1:0]       meter_mem [METER_GROUPS];
    logic [MCNT_W-1:0]       meter_rdata_reg;
    logic [METER_GROUPS-1:0] mvalid_reg;
    logic                    mw_valid_reg;
    logic [MIDX_W-1:0]       mw_idx_reg;
    logic [MCNT_W-1:0]       mw_data_reg;
    logic                    mwe;
    logic                    mre;
    logic [MIDX_W-1:0]       mraddr;
    logic [TOTAL_W-1:0]      scan_cnt_reg;

    // incoming meter group
    logic [METER_GROUPS:0] ge;
    logic [MIDX_W-1:0]     m_in;
    logic                  m_ok_in;

    // observe compute
    logic [SLOT_W-1:0] c_cur;
    logic [SLOT_W-1:0] reload;
    logic [SLOT_W-1:0] cnt_new;
    logic              cnt_wr;
    logic              v_act;
    logic              v_inact;
    logic              v_clr;
    logic [MCNT_W-1:0] mcnt_old;

    // end-of-scan sequencer
    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [MIDX_W-1:0] m_walk_reg;
    logic              walk_end;
    logic              rate_last;
    logic              div_start;
    logic              div_done;
    logic [RATE_W-1:0] per_avg;
    logic [RATE_W-1:0] per_peak;
    logic              walk_clr;
    logic              walk_inc;
    logic              walk_read;
    logic              load_rate;
    logic              clear_counts;
    logic [PROD_W-1:0] prod_avg;
    logic [PROD_W-1:0] prod_peak;
    logic [RATE_W-1:0] sat_avg;
    logic [RATE_W-1:0] sat_peak;

    // output register
    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_act_reg;
    logic                  out_inact_reg;
    logic                  out_clr_reg;
    logic [MIDX_OUT_W-1:0] out_meter_reg;
    logic [RATE_W-1:0]     out_avg_reg;
    logic [RATE_W-1:0]     out_peak_reg;
    logic                  out_last_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg          <= LIMIT_RESET;
            average_rate_budget_reg <= '0;
            peak_rate_budget_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDLE_LIMIT:   idle_limit_reg          <= cfg_data[SLOT_W-1:0];
                CFG_AVERAGE_RATE: average_rate_budget_reg <= cfg_data[RATE_W-1:0];
                CFG_PEAK_RATE:    peak_rate_budget_reg    <= cfg_data[RATE_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = clr_busy_reg || (state_reg != SEQ_IDLE) || (s1_valid_reg && !out_free);
    assign in_acc   = in_valid && !in_stall;
    assign obs_acc  = in_acc && (command == CMD_OBSERVE);
    assign eos_acc  = in_acc && (command == CMD_END_SCAN);

    // meter group of the incoming slot, from threshold compares
    always_comb
    begin
        m_in = '0;
        for (int k = 0; k <= METER_GROUPS; k++)
        begin
            ge[k] = ({16'd0, address_index} >= 32'(k * SLOTS_PER_METER));
        end
        for (int k = 0; k < METER_GROUPS; k++)
        begin
            if (ge[k] && !ge[k+1])
            begin
                m_in = m_in | MIDX_W'(k);
            end
        end
        m_ok_in = !ge[METER_GROUPS];
    end

    // ---------------------------------------------------------------- clear pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- observe stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (obs_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (obs_acc)
        begin
            s1_addr_reg     <= address_index;
            s1_seen_reg     <= seen;
            s1_in_range_reg <= ({1'b0, address_index} < SLOT_LIMIT);
            s1_m_reg        <= m_in;
            s1_m_ok_reg     <= m_ok_in;
            s1_mvalid_reg   <= mvalid_reg[m_in];
        end
    end

    // latest write wins over the registered read
    assign c_cur  = (lw_valid_reg && (lw_idx_reg == s1_addr_reg[IDX_W-1:0])) ?
                    lw_data_reg : cnt_rdata_reg;
    assign reload = (idle_limit_reg == '1) ? idle_limit_reg : (idle_limit_reg + 1'b1);

    always_comb
    begin
        cnt_new = c_cur;
        cnt_wr  = 1'b0;
        v_act   = 1'b0;
        v_inact = 1'b0;
        v_clr   = 1'b0;
        if (s1_in_range_reg)
        begin
            if (s1_seen_reg)
            begin
                cnt_new = reload;
                cnt_wr  = 1'b1;
                v_act   = (c_cur == '0);
                v_clr   = 1'b1;
            end
            else if (c_cur > 16'd1)
            begin
                cnt_new = c_cur - 1'b1;
                cnt_wr  = 1'b1;
            end
            else if (c_cur == 16'd1)
            begin
                cnt_new = '0;
                cnt_wr  = 1'b1;
                v_inact = 1'b1;
            end
        end
    end

    assign cnt_we    = clr_busy_reg || (s1_adv && cnt_wr);
    assign cnt_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg[IDX_W-1:0];
    assign cnt_wdata = clr_busy_reg ? LIMIT_RESET : cnt_new;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (obs_acc)
        begin
            cnt_rdata_reg <= cnt_mem[address_index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (clr_busy_reg)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (cnt_we)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            lw_idx_reg  <= cnt_waddr;
            lw_data_reg <= cnt_wdata;
        end
    end

    // ---------------------------------------------------------------- meter counts
    // an entry whose valid bit is clear reads as zero; valid also means nonzero
    assign mcnt_old = (mw_valid_reg && (mw_idx_reg == s1_m_reg)) ? mw_data_reg :
                      (s1_mvalid_reg ? meter_rdata_reg : '0);
    assign mwe      = s1_adv && v_inact && s1_m_ok_reg && (mcnt_old != METER_CNT_MAX);
    assign mre      = obs_acc || walk_read;
    assign mraddr   = walk_read ? m_walk_reg : m_in;

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            meter_mem[s1_m_reg] <= mcnt_old + 1'b1;
        end
        if (mre)
        begin
            meter_rdata_reg <= meter_mem[mraddr];
        end
        if (mwe)
        begin
            mw_idx_reg  <= s1_m_reg;
            mw_data_reg <= mcnt_old + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg   <= '0;
            mw_valid_reg <= 1'b0;
            scan_cnt_reg <= '0;
        end
        else if (clear_counts)
        begin
            mvalid_reg   <= '0;
            mw_valid_reg <= 1'b0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            if (mwe)
            begin
                mvalid_reg[s1_m_reg] <= 1'b1;
                mw_valid_reg         <= 1'b1;
            end
            if (s1_adv && v_inact && (scan_cnt_reg != SCAN_CNT_MAX))
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- end of scan
    aat_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (scan_cnt_reg),
        .dividend_a (average_rate_budget_reg),
        .dividend_b (peak_rate_budget_reg),
        .done       (div_done),
        .ceil_a     (per_avg),
        .ceil_b     (per_peak)
    );

    assign walk_end = (m_walk_reg == MIDX_W'(METER_GROUPS - 1));

    always_comb
    begin
        rate_last = 1'b1;
        for (int k = 0; k < METER_GROUPS; k++)
        begin
            if ((MIDX_W'(k) > m_walk_reg) && mvalid_reg[k])
            begin
                rate_last = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (eos_acc)
                begin
                    state_next = SEQ_START;
                end
            end
            SEQ_START:
            begin
                state_next = (scan_cnt_reg == '0) ? SEQ_CLEAR : SEQ_DIV;
            end
            SEQ_DIV:
            begin
                if (div_done)
                begin
                    state_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                if (mvalid_reg[m_walk_reg])
                begin
                    state_next = SEQ_EMIT;
                end
                else if (walk_end)
                begin
                    state_next = SEQ_CLEAR;
                end
            end
            SEQ_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rate_last ? SEQ_CLEAR : SEQ_READ;
                end
            end
            SEQ_CLEAR:
            begin
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        walk_clr     = 1'b0;
        walk_inc     = 1'b0;
        walk_read    = 1'b0;
        load_rate    = 1'b0;
        clear_counts = 1'b0;
        case (state_reg)
            SEQ_START:
            begin
                walk_clr  = 1'b1;
                div_start = (scan_cnt_reg != '0);
            end
            SEQ_READ:
            begin
                walk_read = mvalid_reg[m_walk_reg];
                walk_inc  = !mvalid_reg[m_walk_reg] && !walk_end;
            end
            SEQ_EMIT:
            begin
                load_rate = out_free;
                walk_inc  = out_free && !rate_last;
            end
            SEQ_CLEAR:
            begin
                clear_counts = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            m_walk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (walk_clr)
            begin
                m_walk_reg <= '0;
            end
            else if (walk_inc)
            begin
                m_walk_reg <= m_walk_reg + 1'b1;
            end
        end
    end

    assign prod_avg  = PROD_W'(per_avg) * PROD_W'(meter_rdata_reg);
    assign prod_peak = PROD_W'(per_peak) * PROD_W'(meter_rdata_reg);
    assign sat_avg   = (prod_avg[PROD_W-1:RATE_W] != '0) ? '1 : prod_avg[RATE_W-1:0];
    assign sat_peak  = (prod_peak[PROD_W-1:RATE_W] != '0) ? '1 : prod_peak[RATE_W-1:0];

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv || load_rate)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_kind_reg  <= KIND_VERDICT;
            out_slot_reg  <= s1_addr_reg;
            out_act_reg   <= v_act;
            out_inact_reg <= v_inact;
            out_clr_reg   <= v_clr;
            out_meter_reg <= '0;
            out_avg_reg   <= '0;
            out_peak_reg  <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (load_rate)
        begin
            out_kind_reg  <= KIND_RATE;
            out_slot_reg  <= '0;
            out_act_reg   <= 1'b0;
            out_inact_reg <= 1'b0;
            out_clr_reg   <= 1'b0;
            out_meter_reg <= MIDX_OUT_W'(m_walk_reg);
            out_avg_reg   <= sat_avg;
            out_peak_reg  <= sat_peak;
            out_last_reg  <= rate_last;
        end
    end

    assign out_valid           = out_valid_reg;
    assign kind                = out_kind_reg;
    assign slot                = out_slot_reg;
    assign set_global_active   = out_act_reg;
    assign set_global_inactive = out_inact_reg;
    assign clear_flag          = out_clr_reg;
    assign meter_index         = out_meter_reg;
    assign meter_average_rate  = out_avg_reg;
    assign meter_peak_rate     = out_peak_reg;
    assign last                = out_last_reg;

endmodule

>>> rtl/core/aat_checker.sv
`timescale 1ns / 1ps

module aat_checker
    import aat_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  kind,
    input logic [SLOT_W-1:0]     slot,
    input logic                  set_global_active,
    input logic                  set_global_inactive,
    input logic                  clear_flag,
    input logic [MIDX_OUT_W-1:0] meter_index,
    input logic [RATE_W-1:0]     meter_average_rate,
    input logic [RATE_W-1:0]     meter_peak_rate,
    input logic                  last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot)
            && $stable(meter_index) && $stable(meter_average_rate)
            && $stable(meter_peak_rate) && $stable(last))
        else $error("result changed while stalled");

    a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_VERDICT) |-> !(set_global_active && set_global_inactive))
        else $error("slot marked active and inactive at once");

    a_active_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_global_active |-> clear_flag && !set_global_inactive)
        else $error("reactivation without flag clear");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_VERDICT) |-> last && (meter_average_rate == '0)
            && (meter_peak_rate == '0))
        else $error("verdict not single or carries rates");

    a_rate_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_RATE) |-> (slot == '0) && !set_global_active
            && !set_global_inactive && !clear_flag)
        else $error("rate update carries verdict bits");

endmodule

bind address_activity_aging_table_top aat_checker u_aat_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import aat_pkg::*;

    localparam int NUM_SLOTS       = 65536;
    localparam int SLOTS_PER_GROUP = 1024;
    localparam int NUM_GROUPS      = 64;
    localparam int SETTLE_CYCLES   = 200;
    localparam int LIMIT_CYCLES    = 1_000_000;

    typedef struct packed {
        logic                  kind;
        logic [SLOT_W-1:0]     slot;
        logic                  set_active;
        logic                  set_inactive;
        logic                  clear_flag;
        logic [MIDX_OUT_W-1:0] meter;
        logic [RATE_W-1:0]     avg_rate;
        logic [RATE_W-1:0]     peak_rate;
        logic                  last;
    } table_update_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = CMD_OBSERVE;
    logic [SLOT_W-1:0]     address_index = '0;
    logic                  seen = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [SLOT_W-1:0]     slot;
    logic                  set_global_active;
    logic                  set_global_inactive;
    logic                  clear_flag;
    logic [MIDX_OUT_W-1:0] meter_index;
    logic [RATE_W-1:0]     meter_average_rate;
    logic [RATE_W-1:0]     meter_peak_rate;
    logic                  last;

    // mirror of the aging table and scan counts
    logic [SLOT_W-1:0]  idle_count [NUM_SLOTS];
    logic [MCNT_W-1:0]  meter_idle_new [NUM_GROUPS];
    logic [TOTAL_W-1:0] scan_idle_new;
    logic [SLOT_W-1:0]  limit_reg;
    logic [RATE_W-1:0]  avg_budget;
    logic [RATE_W-1:0]  peak_budget;

    table_update_t awaited_updates [$];
    table_update_t want_update;

    int   mismatches = 0;
    int   results_checked = 0;
    int   rate_updates = 0;
    int   items_sent = 0;
    int   scans_sent = 0;
    int   burst_left = 0;
    bit   sender_idling = 1'b1;
    logic [15:0] stall_clock = '0;

    address_activity_aging_table_top #(
        .ADDRESS_SLOTS  (NUM_SLOTS),
        .SLOTS_PER_METER(SLOTS_PER_GROUP),
        .METER_GROUPS   (NUM_GROUPS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .address_index      (address_index),
        .seen               (seen),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .slot               (slot),
        .set_global_active  (set_global_active),
        .set_global_inactive(set_global_inactive),
        .clear_flag         (clear_flag),
        .meter_index        (meter_index),
        .meter_average_rate (meter_average_rate),
        .meter_peak_rate    (meter_peak_rate),
        .last               (last)
    );

    always #5 clk = ~clk;

    // receiver back-pressure: windows of differing stall density, chosen by bits 10:8 of a free-running counter
    always @(posedge clk)
    begin
        stall_clock <= stall_clock + 16'd1;
        case (stall_clock[10:8])
            3'd0, 3'd1: out_stall <= 1'b0;
            3'd2, 3'd3: out_stall <= ($urandom_range(0, 3) == 0);
            3'd4:       out_stall <= $urandom_range(0, 1);
            3'd5:       out_stall <= (stall_clock[3:0] < 4'd12);
            default:    out_stall <= ($urandom_range(0, 9) == 0);
        endcase
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Timed out with %0d results still outstanding", awaited_updates.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [RATE_W-1:0] rate_share(input logic [RATE_W-1:0] budget,
                                                     input logic [TOTAL_W-1:0] total,
                                                     input logic [MCNT_W-1:0] count);
        logic [63:0] per_slot;
        logic [63:0] share;
        per_slot = ({32'd0, budget} + {47'd0, total} - 64'd1) / {47'd0, total};
        share = per_slot * {53'd0, count};
        return (share > 64'hFFFF_FFFF) ? '1 : share[RATE_W-1:0];
    endfunction

    task automatic queue_update(input table_update_t u);
        awaited_updates.insert(awaited_updates.size(), u);
    endtask

    task automatic predict_item(input logic cmd, input logic [SLOT_W-1:0] addr,
                                input logic sn);
        table_update_t u;
        logic [SLOT_W-1:0] cnt;
        logic [SLOT_W:0]   reload;
        int m;
        int last_m;
        if (cmd == CMD_OBSERVE)
        begin
            u = '0;
            u.kind = KIND_VERDICT;
            u.slot = addr;
            u.last = 1'b1;
            if (addr < NUM_SLOTS)
            begin
                cnt = idle_count[addr];
                if (sn)
                begin
                    reload = {1'b0, limit_reg} + 17'd1;
                    if (reload > 17'h0FFFF)
                        reload = 17'h0FFFF;
                    u.set_active = (cnt == 0);
                    u.clear_flag = 1'b1;
                    idle_count[addr] = reload[SLOT_W-1:0];
                end
                else if (cnt > 1)
                    idle_count[addr] = cnt - 1'b1;
                else if (cnt == 1)
                begin
                    idle_count[addr] = '0;
                    u.set_inactive = 1'b1;
                    if (scan_idle_new < SCAN_CNT_MAX)
                        scan_idle_new = scan_idle_new + 1'b1;
                    m = addr / SLOTS_PER_GROUP;
                    if (m < NUM_GROUPS && meter_idle_new[m] < METER_CNT_MAX)
                        meter_idle_new[m] = meter_idle_new[m] + 1'b1;
                end
            end
            queue_update(u);
        end
        else
        begin
            last_m = -1;
            for (m = 0; m < NUM_GROUPS; m++)
                if (meter_idle_new[m] != 0)
                    last_m = m;
            if (scan_idle_new != 0)
            begin
                for (m = 0; m < NUM_GROUPS; m++)
                begin
                    if (meter_idle_new[m] != 0)
                    begin
                        u = '0;
                        u.kind = KIND_RATE;
                        u.meter = m[MIDX_OUT_W-1:0];
                        u.avg_rate = rate_share(avg_budget, scan_idle_new, meter_idle_new[m]);
                        u.peak_rate = rate_share(peak_budget, scan_idle_new, meter_idle_new[m]);
                        u.last = (m == last_m);
                        queue_update(u);
                    end
                end
            end
            for (m = 0; m < NUM_GROUPS; m++)
                meter_idle_new[m] = '0;
            scan_idle_new = '0;
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                         what, results_checked, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (awaited_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d: kind %0b slot %0h meter %0d",
                             results_checked, kind, slot, meter_index);
            end
            else
            begin
                want_update = awaited_updates.pop_front();
                if (want_update.kind == KIND_RATE)
                    rate_updates++;
                compare_field("kind", want_update.kind, kind);
                compare_field("slot", want_update.slot, slot);
                compare_field("set_global_active", want_update.set_active, set_global_active);
                compare_field("set_global_inactive", want_update.set_inactive,
                              set_global_inactive);
                compare_field("clear_flag", want_update.clear_flag, clear_flag);
                compare_field("meter_index", want_update.meter, meter_index);
                compare_field("meter_average_rate", want_update.avg_rate, meter_average_rate);
                compare_field("meter_peak_rate", want_update.peak_rate, meter_peak_rate);
                compare_field("last", want_update.last, last);
            end
        end
    end

    // called on a rising edge; returns on the edge at which the item is taken
    task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] addr, input logic sn);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idling ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= cmd;
        address_index <= addr;
        seen <= sn;
        do @(posedge clk); while (in_stall);
        predict_item(cmd, addr, sn);
        items_sent++;
        if (cmd == CMD_END_SCAN)
            scans_sent++;
    endtask

    task automatic end_scan();
        send_item(CMD_END_SCAN, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    // seen, then unseen twice: with an idle limit of 1 the slot goes inactive
    task automatic age_out_slot(input logic [SLOT_W-1:0] addr);
        send_item(CMD_OBSERVE, addr, 1'b1);
        send_item(CMD_OBSERVE, addr, 1'b0);
        send_item(CMD_OBSERVE, addr, 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (awaited_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IDLE_LIMIT:   limit_reg = value[SLOT_W-1:0];
            CFG_AVERAGE_RATE: avg_budget = value;
            CFG_PEAK_RATE:    peak_budget = value;
            default:          ;
        endcase
    endtask

    task automatic test_power_on_defaults();
        send_item(CMD_OBSERVE, 16'h0000, 1'b0);
        send_item(CMD_OBSERVE, 16'hFFFF, 1'b1);
        send_item(CMD_OBSERVE, 16'h0000, 1'b0);
        send_item(CMD_OBSERVE, 16'h0000, 1'b0);
        end_scan();     // zero budgets still give a rate update for meter 0
        end_scan();     // nothing inactive: no result
    endtask

    task automatic test_directed_aging();
        settle();
        write_reg(CFG_IDLE_LIMIT, 32'd1);
        write_reg(CFG_AVERAGE_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_PEAK_RATE, 32'd7);
        send_item(CMD_OBSERVE, 16'h0000, 1'b0);     // counter already zero
        age_out_slot(16'h0000);                     // reactivates, then idles out
        repeat (4) send_item(CMD_OBSERVE, 16'hFFFF, 1'b0);
        age_out_slot(16'hAAAA);
        age_out_slot(16'h5555);
        end_scan();
        // two in one meter of a total of two: average share saturates
        age_out_slot(16'h0002);
        age_out_slot(16'h0003);
        end_scan();
    endtask

    task automatic test_reload_ceiling();
        settle();
        write_reg(CFG_IDLE_LIMIT, 32'd65535);
        send_item(CMD_OBSERVE, 16'h1234, 1'b1);
        send_item(CMD_OBSERVE, 16'h1234, 1'b0);
        end_scan();
    endtask

    task automatic test_meter_walk();
        int i;
        settle();
        write_reg(CFG_IDLE_LIMIT, 32'd1);
        write_reg(CFG_PEAK_RATE, 32'd12345);
        sender_idling = 1'b0;
        // one slot in each of eight meters spread from first to last, two in meter 5
        for (i = 0; i < 8; i++)
            age_out_slot({6'(i * 9), 10'd7});
        age_out_slot({6'd5, 10'd1});
        age_out_slot({6'd5, 10'd2});
        end_scan();
        sender_idling = 1'b1;
    endtask

    task automatic test_random_scans();
        logic [SLOT_W-1:0] pool [12];
        logic [5:0]        base_meter;
        int phase;
        int n;
        int pick;
        int r;
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            if (phase == 0)
                write_reg(CFG_IDLE_LIMIT, 32'd65534);
            else
                write_reg(CFG_IDLE_LIMIT, $urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_AVERAGE_RATE, 32'd0);
                1:       write_reg(CFG_AVERAGE_RATE, 32'hFFFF_FFFF);
                default: write_reg(CFG_AVERAGE_RATE, $urandom);
            endcase
            write_reg(CFG_PEAK_RATE, (phase == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 100000));
            sender_idling = (phase != 2);
            base_meter = 6'($urandom_range(0, 63));
            for (n = 0; n < 12; n++)
                pool[n] = (n < 6) ? {base_meter, 10'($urandom_range(0, 1023))}
                                  : 16'($urandom_range(0, 65535));
            for (n = 0; n < 33; n++)
            begin
                r = $urandom_range(0, 99);
                pick = $urandom_range(0, 11);
                if (r < 8)
                    end_scan();
                else if (r < 16)
                    send_item(CMD_OBSERVE, 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
                else
                    send_item(CMD_OBSERVE, pool[pick], ($urandom_range(0, 3) == 0));
            end
            end_scan();
        end
        sender_idling = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            idle_count[i] = LIMIT_RESET;
        for (int i = 0; i < NUM_GROUPS; i++)
            meter_idle_new[i] = '0;
        scan_idle_new = '0;
        limit_reg = LIMIT_RESET;
        avg_budget = '0;
        peak_budget = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_directed_aging();
        test_reload_ceiling();
        test_meter_walk();
        test_random_scans();
        settle();

        $display("Sent %0d items (%0d end-of-scan); checked %0d results, %0d meter rate updates",
                 items_sent, scans_sent, results_checked, rate_updates);
        $display("Idle limits 1 to 65535, budgets 0 to full scale, rate saturation, meters 0 to 63");
        if (mismatches == 0 && awaited_updates.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     awaited_updates.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/aat_pkg.sv
rtl/core/aat_divider.sv
rtl/core/address_activity_aging_table_top.sv
rtl/core/aat_checker.sv
verif/tb.sv
